>>> design/sibd_pkg.sv
// Shared constants, types and helpers for the signed integer to base digits block.
package sibd_pkg;

    localparam int VALUE_BITS_DEFAULT = 8;
    localparam int RADIX_BITS  = 6;
    localparam int DIGIT_BITS  = 6;
    localparam int CHAR_BITS   = 7;

    localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd16;
    localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;

    localparam logic [CHAR_BITS-1:0] CH_ZERO    = 7'd48;
    localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 7'd65;
    localparam logic [CHAR_BITS-1:0] CH_MINUS   = 7'd45;
    localparam logic [DIGIT_BITS-1:0] TEN       = 6'd10;

    typedef struct packed {
        logic load;
        logic step;
        logic store;
        logic push_sign;
        logic push_digit;
    } sibd_cmd_t;

    typedef struct packed {
        logic div_last;
        logic quo_zero;
        logic store_full;
        logic negative;
        logic out_free;
        logic digit_one;
    } sibd_sts_t;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] d_ext;
        d_ext = {1'b0, d};
        if (d < TEN) begin
            digit_char = d_ext + CH_ZERO;
        end else begin
            digit_char = d_ext - {1'b0, TEN} + CH_UPPER_A;
        end
    endfunction

    function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] r);
        if (r < RADIX_MIN) begin
            clamp_radix = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            clamp_radix = RADIX_MAX;
        end else begin
            clamp_radix = r;
        end
    endfunction

endpackage

>>> design/sibd_datapath.sv
// Datapath: base register, bit-serial divider, digit store and output register.
module sibd_datapath #(
    parameter int VALUE_BITS = sibd_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [sibd_pkg::RADIX_BITS-1:0]     cfg_radix,
    input  logic signed [VALUE_BITS-1:0]        s_value,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [sibd_pkg::CHAR_BITS-1:0]      m_character,
    output logic                                m_last,
    input  sibd_pkg::sibd_cmd_t                 cmd,
    output sibd_pkg::sibd_sts_t                 sts
);

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);
    localparam int IDX_BITS = $clog2(VALUE_BITS);
    localparam int DB = sibd_pkg::DIGIT_BITS;

    logic [sibd_pkg::RADIX_BITS-1:0] base_reg;
    logic [VALUE_BITS-1:0]           div_reg;
    logic [DB-1:0]                   rem_reg;
    logic [IDX_BITS-1:0]             bit_cnt_reg;
    logic [CNT_BITS-1:0]             digit_cnt_reg;
    logic                            neg_reg;
    logic [DB-1:0]                   digits_reg [VALUE_BITS];
    logic                            m_valid_reg;
    logic [sibd_pkg::CHAR_BITS-1:0]  m_character_reg;
    logic                            m_last_reg;

    logic [DB:0]           trial;
    logic [DB:0]           diff;
    logic                  q_bit;
    logic [VALUE_BITS-1:0] mag;
    logic [CNT_BITS-1:0]   rd_cnt;
    logic [IDX_BITS-1:0]   rd_idx;

    assign trial  = {rem_reg, div_reg[VALUE_BITS-1]};
    assign diff   = trial - {1'b0, base_reg};
    assign q_bit  = (trial >= {1'b0, base_reg});
    assign mag    = s_value[VALUE_BITS-1] ? (~s_value + 1'b1) : s_value;
    assign rd_cnt = digit_cnt_reg - 1'b1;
    assign rd_idx = rd_cnt[IDX_BITS-1:0];

    assign sts.div_last   = (bit_cnt_reg == IDX_BITS'(VALUE_BITS - 1));
    assign sts.quo_zero   = (div_reg == '0);
    assign sts.store_full = (digit_cnt_reg == CNT_BITS'(VALUE_BITS - 1));
    assign sts.negative   = neg_reg;
    assign sts.out_free   = !m_valid_reg || m_ready;
    assign sts.digit_one  = (digit_cnt_reg == CNT_BITS'(1));

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= sibd_pkg::RADIX_RESET;
            bit_cnt_reg   <= '0;
            digit_cnt_reg <= '0;
            neg_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                base_reg <= sibd_pkg::clamp_radix(cfg_radix);
            end
            if (cmd.load) begin
                div_reg       <= mag;
                neg_reg       <= s_value[VALUE_BITS-1];
                rem_reg       <= '0;
                bit_cnt_reg   <= '0;
                digit_cnt_reg <= '0;
            end
            if (cmd.step) begin
                div_reg     <= {div_reg[VALUE_BITS-2:0], q_bit};
                rem_reg     <= q_bit ? diff[DB-1:0] : trial[DB-1:0];
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end
            if (cmd.store) begin
                digits_reg[digit_cnt_reg[IDX_BITS-1:0]] <= rem_reg;
                digit_cnt_reg <= digit_cnt_reg + 1'b1;
                rem_reg       <= '0;
                bit_cnt_reg   <= '0;
            end
            if (cmd.push_sign) begin
                m_valid_reg     <= 1'b1;
                m_character_reg <= sibd_pkg::CH_MINUS;
                m_last_reg      <= 1'b0;
            end else if (cmd.push_digit) begin
                m_valid_reg     <= 1'b1;
                m_character_reg <= sibd_pkg::digit_char(digits_reg[rd_idx]);
                m_last_reg      <= (digit_cnt_reg == CNT_BITS'(1));
                digit_cnt_reg   <= rd_cnt;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> design/sibd_ctrl.sv
// Controller: sequences load, division, digit store and character output.
module sibd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output sibd_pkg::sibd_cmd_t cmd,
    input  sibd_pkg::sibd_sts_t sts
);

    typedef enum logic [2:0] {
        IDLE,
        DIVIDE,
        STORE,
        SIGN,
        EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = DIVIDE;
                end
            end
            DIVIDE: begin
                cmd.step = 1'b1;
                if (sts.div_last) begin
                    state_next = STORE;
                end
            end
            STORE: begin
                cmd.store = 1'b1;
                if (sts.quo_zero || sts.store_full) begin
                    state_next = sts.negative ? SIGN : EMIT;
                end else begin
                    state_next = DIVIDE;
                end
            end
            SIGN: begin
                if (sts.out_free) begin
                    cmd.push_sign = 1'b1;
                    state_next    = EMIT;
                end
            end
            EMIT: begin
                if (sts.out_free) begin
                    cmd.push_digit = 1'b1;
                    if (sts.digit_one) begin
                        state_next = IDLE;
                    end
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/signed_int_to_base_digits.sv
// Top level: signed integer to ASCII text in a configurable base.
//
//  channel  direction  beat
//  s_       in         value, VALUE_BITS-bit two's complement
//  m_       out        character (7-bit ASCII) and last
//  cfg_     in         radix, 6 bits, clamped to 2..36
//
// One bit-serial divider produces each digit in VALUE_BITS shift-subtract
// steps and one store; once all digits are stored, the characters follow at
// one character per cycle while m_ready does not stall the output.
// Reset sets the base to 16 and empties the output register.
// A stall on m_ready holds the sequencer; the next value is taken once the
// final character sits in the output register.
module signed_int_to_base_digits #(
    parameter int VALUE_BITS = sibd_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [VALUE_BITS-1:0]     s_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [sibd_pkg::CHAR_BITS-1:0]   m_character,
    output logic                             m_last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sibd_pkg::RADIX_BITS-1:0]  cfg_radix
);

    sibd_pkg::sibd_cmd_t cmd;
    sibd_pkg::sibd_sts_t sts;

    assign cfg_ready = 1'b1;

    sibd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    sibd_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_radix   (cfg_radix),
        .s_value     (s_value),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_character (m_character),
        .m_last      (m_last),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
